FILE: design/wconv_pkg.sv
// Shared types and constants for the weighted 3x3 convolution filter.
`timescale 1ns / 1ps

package wconv_pkg;

  // Pixel, weight and default frame limits.
  localparam int PIX_W        = 8;
  localparam int WEIGHT_W     = 8;
  localparam int KREG_W       = 3 * WEIGHT_W;
  localparam int DIM_W        = 11;
  localparam int CFG_DATA_W   = KREG_W;
  localparam int CFG_ADDR_W   = 3;
  localparam int MAX_WIDTH_D  = 1024;
  localparam int MAX_HEIGHT_D = 1024;
  localparam int PIX_MAX      = (1 << PIX_W) - 1;

  // Arithmetic widths: one product, one row of three, and the full window.
  localparam int PROD_W = PIX_W + WEIGHT_W;
  localparam int ROW_W  = PROD_W + 2;
  localparam int SUM_W  = PROD_W + 4;

  // Division by 17 as multiplication by a rounded-up reciprocal. The error
  // term of the reciprocal times the largest sum stays below 2**DIV_SHIFT,
  // so the truncated product equals the truncated quotient.
  localparam int DIVISOR   = 17;
  localparam int DIV_SHIFT = SUM_W + 8;
  localparam int DIV_MULT  = ((1 << DIV_SHIFT) + DIVISOR - 1) / DIVISOR;
  localparam int MULT_W    = $clog2(DIV_MULT + 1);
  localparam int QPROD_W   = SUM_W + MULT_W;
  localparam int QUO_W     = QPROD_W - DIV_SHIFT;

  // Register indexes of the configuration port.
  localparam logic [CFG_ADDR_W-1:0] CFG_KERNEL_ROW_ZERO = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_KERNEL_ROW_ONE  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_KERNEL_ROW_TWO  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_LINE_WIDTH      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_HEIGHT    = 3'd4;

  // Reset values of the registers.
  localparam logic [KREG_W-1:0] KERNEL_ROW_ZERO_RST = 24'h010201;
  localparam logic [KREG_W-1:0] KERNEL_ROW_ONE_RST  = 24'h020502;
  localparam logic [KREG_W-1:0] KERNEL_ROW_TWO_RST  = 24'h010201;
  localparam logic [DIM_W-1:0]  LINE_WIDTH_RST      = 11'd5;
  localparam logic [DIM_W-1:0]  FRAME_HEIGHT_RST    = 11'd4;
  localparam int                MIN_DIM             = 3;

  // Per-item control that travels with the window down the pipeline.
  typedef struct packed {
    logic emit;
    logic last;
    logic mask_top;
    logic mask_bot;
    logic mask_left;
    logic mask_right;
  } win_ctrl_t;

endpackage

FILE: design/weighted_3x3_convolution.sv
// Weighted 3x3 convolution filter over a raster pixel stream, divide by 17.
// Throughput: one beat per cycle on both sides while the receiver is ready; all stages advance together.
// Stages s1 to s6 and the output register lie between the beat that completes a
// window and its result; that beat arrives one line plus one pixel after the pixel itself.
// Both line stores share one memory, read at acceptance, written back as the beat leaves the first stage.
// Reset (synchronous, active low) restores weights and geometry and restarts the frame.
`timescale 1ns / 1ps

module weighted_3x3_convolution #(
  parameter int MAX_WIDTH  = wconv_pkg::MAX_WIDTH_D,
  parameter int MAX_HEIGHT = wconv_pkg::MAX_HEIGHT_D
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [wconv_pkg::PIX_W-1:0]      in_pixel_value,
  input  logic                             in_flush,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [wconv_pkg::PIX_W-1:0]      out_filtered_value,
  output logic                             out_saturated,
  output logic                             out_last_of_frame,
  input  logic                             cfg_we,
  input  logic [wconv_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [wconv_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
  localparam int PW    = wconv_pkg::PIX_W;
  localparam int MEM_W = 2 * PW;

  // Clamps a written dimension to the supported range.
  function automatic int clamp_dim(logic [wconv_pkg::DIM_W-1:0] v, int hi);
    int val;
    val = int'(v);
    if (val < wconv_pkg::MIN_DIM) begin
      return wconv_pkg::MIN_DIM;
    end else if (val > hi) begin
      return hi;
    end
    return val;
  endfunction

  // Configuration and position state.
  logic [2:0][wconv_pkg::KREG_W-1:0] kernel_r, kernel_nxt;
  logic [WID_W-1:0] width_r, width_nxt;
  logic [ROW_W-1:0] height_r, height_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  // Pipeline valid bits and the global advance.
  logic advance;
  logic accept;
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, out_v_r;

  // Stage payloads.
  logic [MEM_W-1:0]          line_mem [MAX_WIDTH];
  logic [MEM_W-1:0]          line_rd_r;
  logic [COL_W-1:0]          s1_col_r;
  logic [PW-1:0]             s1_pix_r, pix_nxt;
  wconv_pkg::win_ctrl_t      s1_ctrl_r, ctrl_nxt, s2_ctrl_r;
  logic [PW-1:0]             win_r [9];
  logic [PW-1:0]             win_nxt [9];
  logic [wconv_pkg::PROD_W-1:0] prod_r [9];
  logic [wconv_pkg::PROD_W-1:0] prod_nxt [9];
  logic [wconv_pkg::ROW_W-1:0]  rsum_r [3];
  logic [wconv_pkg::ROW_W-1:0]  rsum_nxt [3];
  logic [wconv_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [wconv_pkg::QPROD_W-1:0] qprod_r, qprod_nxt;
  logic [wconv_pkg::QUO_W-1:0]  quo;
  logic s3_last_r, s4_last_r, s5_last_r, s6_last_r;
  logic [PW-1:0] out_value_r, out_value_nxt;
  logic          out_sat_r, out_sat_nxt, out_last_r;

  // Every stage moves when the output register is free or being taken.
  assign advance  = !out_v_r || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && advance;

  // Window geometry of the incoming beat, decoded from the position.
  logic             col_zero, col_one, row_ge_h, row_ge_h1, row_last;
  logic [WID_W-1:0] col_inc;
  logic [ROW_W-1:0] height_p1;

  always_comb begin
    height_p1 = height_r + ROW_W'(1);
    col_zero  = (col_r == '0);
    col_one   = (col_r == COL_W'(1));
    row_ge_h  = (row_r >= height_r);
    row_ge_h1 = (row_r >= height_p1);
    row_last  = (row_r == height_p1);
    col_inc   = WID_W'(col_r) + WID_W'(1);

    ctrl_nxt.emit       = (row_r >= ROW_W'(2)) || ((row_r == ROW_W'(1)) && !col_zero);
    ctrl_nxt.last       = row_last;
    ctrl_nxt.mask_top   = col_zero ? (row_r == ROW_W'(2)) : (row_r == ROW_W'(1));
    ctrl_nxt.mask_bot   = col_zero ? row_ge_h1 : row_ge_h;
    ctrl_nxt.mask_left  = !col_zero && col_one;
    ctrl_nxt.mask_right = col_zero;

    pix_nxt = (in_flush || row_ge_h) ? '0 : in_pixel_value;
  end

  // Position advance and configuration writes; a geometry write restarts the frame.
  always_comb begin
    kernel_nxt = kernel_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    if (accept) begin
      if (row_last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_inc >= width_r) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = COL_W'(col_inc);
      end
    end
    if (cfg_we) begin
      case (cfg_addr)
        wconv_pkg::CFG_KERNEL_ROW_ZERO: kernel_nxt[0] = cfg_wdata;
        wconv_pkg::CFG_KERNEL_ROW_ONE:  kernel_nxt[1] = cfg_wdata;
        wconv_pkg::CFG_KERNEL_ROW_TWO:  kernel_nxt[2] = cfg_wdata;
        wconv_pkg::CFG_LINE_WIDTH: begin
          width_nxt = WID_W'(clamp_dim(cfg_wdata[wconv_pkg::DIM_W-1:0], MAX_WIDTH));
          col_nxt   = '0;
          row_nxt   = '0;
        end
        wconv_pkg::CFG_FRAME_HEIGHT: begin
          height_nxt = ROW_W'(clamp_dim(cfg_wdata[wconv_pkg::DIM_W-1:0], MAX_HEIGHT));
          col_nxt    = '0;
          row_nxt    = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_r[0] <= wconv_pkg::KERNEL_ROW_ZERO_RST;
      kernel_r[1] <= wconv_pkg::KERNEL_ROW_ONE_RST;
      kernel_r[2] <= wconv_pkg::KERNEL_ROW_TWO_RST;
      width_r     <= WID_W'(clamp_dim(wconv_pkg::LINE_WIDTH_RST, MAX_WIDTH));
      height_r    <= ROW_W'(clamp_dim(wconv_pkg::FRAME_HEIGHT_RST, MAX_HEIGHT));
      col_r       <= '0;
      row_r       <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      s6_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      kernel_r <= kernel_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      if (advance) begin
        s1_v_r  <= in_valid;
        s2_v_r  <= s1_v_r;
        s3_v_r  <= s2_v_r && s2_ctrl_r.emit;
        s4_v_r  <= s3_v_r;
        s5_v_r  <= s4_v_r;
        s6_v_r  <= s5_v_r;
        out_v_r <= s6_v_r;
      end
    end
  end

  // Line store memory: upper line in the high byte, lower line in the low byte.
  // Read at acceptance; the same column is written back as the beat leaves the
  // first stage. Within a frame the next access to that column is a line width
  // (at least three beats) away. At the frame wrap column zero is read again by
  // the very next beat, before the drain beat's write lands; that older word
  // only reaches window cells that the frame-edge masking zeroes.
  always_ff @(posedge clk) begin
    if (accept) begin
      line_rd_r <= line_mem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_v_r) begin
      line_mem[s1_col_r] <= {line_rd_r[PW-1:0], s1_pix_r};
    end
  end

  // Window shift: old columns move left, the fetched column enters on the right.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3]     = win_r[r*3+1];
      win_nxt[r*3 + 1] = win_r[r*3+2];
    end
    win_nxt[2] = line_rd_r[MEM_W-1:PW];
    win_nxt[5] = line_rd_r[PW-1:0];
    win_nxt[8] = s1_pix_r;
  end

  // Weighted products; neighbors outside the frame contribute zero.
  always_comb begin
    logic masked;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        masked = ((r == 0) && s2_ctrl_r.mask_top) || ((r == 2) && s2_ctrl_r.mask_bot) ||
                 ((c == 0) && s2_ctrl_r.mask_left) || ((c == 2) && s2_ctrl_r.mask_right);
        prod_nxt[r*3+c] = masked ? '0 :
            ({{wconv_pkg::WEIGHT_W{1'b0}}, win_r[r*3+c]} *
             {{PW{1'b0}}, kernel_r[c][wconv_pkg::WEIGHT_W*r +: wconv_pkg::WEIGHT_W]});
      end
    end
  end

  // Row sums, then the window total.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rsum_nxt[r] = wconv_pkg::ROW_W'(prod_r[r*3]) + wconv_pkg::ROW_W'(prod_r[r*3+1]) +
                    wconv_pkg::ROW_W'(prod_r[r*3+2]);
    end
    sum_nxt = wconv_pkg::SUM_W'(rsum_r[0]) + wconv_pkg::SUM_W'(rsum_r[1]) +
              wconv_pkg::SUM_W'(rsum_r[2]);
  end

  // Divide by 17 through the reciprocal, then saturate to the pixel range.
  always_comb begin
    qprod_nxt = {{wconv_pkg::MULT_W{1'b0}}, sum_r} *
                {{wconv_pkg::SUM_W{1'b0}}, wconv_pkg::MULT_W'(wconv_pkg::DIV_MULT)};
    quo = qprod_r[wconv_pkg::QPROD_W-1:wconv_pkg::DIV_SHIFT];
    if (quo > wconv_pkg::QUO_W'(wconv_pkg::PIX_MAX)) begin
      out_value_nxt = PW'(wconv_pkg::PIX_MAX);
      out_sat_nxt   = 1'b1;
    end else begin
      out_value_nxt = quo[PW-1:0];
      out_sat_nxt   = 1'b0;
    end
  end

  // Payload registers of all stages.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r  <= col_r;
      s1_pix_r  <= pix_nxt;
      s1_ctrl_r <= ctrl_nxt;
    end
    if (advance) begin
      if (s1_v_r) begin
        win_r <= win_nxt;
      end
      s2_ctrl_r   <= s1_ctrl_r;
      prod_r      <= prod_nxt;
      s3_last_r   <= s2_ctrl_r.last;
      rsum_r      <= rsum_nxt;
      s4_last_r   <= s3_last_r;
      sum_r       <= sum_nxt;
      s5_last_r   <= s4_last_r;
      qprod_r     <= qprod_nxt;
      s6_last_r   <= s5_last_r;
      out_value_r <= out_value_nxt;
      out_sat_r   <= out_sat_nxt;
      out_last_r  <= s6_last_r;
    end
  end

  assign out_valid          = out_v_r;
  assign out_filtered_value = out_value_r;
  assign out_saturated      = out_sat_r;
  assign out_last_of_frame  = out_last_r;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the weighted 3x3 convolution filter.
`timescale 1ns / 1ps

module tb_top;

  localparam int RANDOM_ITEMS  = 480;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int DIM_FIELD_MAX = (1 << wconv_pkg::DIM_W) - 1;
  localparam logic [wconv_pkg::CFG_ADDR_W-1:0] CFG_SPARE_FIRST = 3'd5;
  localparam logic [wconv_pkg::CFG_ADDR_W-1:0] CFG_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [wconv_pkg::PIX_W-1:0] value;
    logic                        sat;
    logic                        last;
  } filtered_pixel_t;

  logic                             clk;
  logic                             rst_n          = 1'b0;
  logic                             in_valid       = 1'b0;
  logic                             in_ready;
  logic [wconv_pkg::PIX_W-1:0]      in_pixel_value = '0;
  logic                             in_flush       = 1'b0;
  logic                             out_valid;
  logic                             out_ready      = 1'b0;
  logic [wconv_pkg::PIX_W-1:0]      out_filtered_value;
  logic                             out_saturated;
  logic                             out_last_of_frame;
  logic                             cfg_we         = 1'b0;
  logic [wconv_pkg::CFG_ADDR_W-1:0] cfg_addr       = wconv_pkg::CFG_KERNEL_ROW_ZERO;
  logic [wconv_pkg::CFG_DATA_W-1:0] cfg_wdata      = '0;

  weighted_3x3_convolution uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_pixel_value     (in_pixel_value),
    .in_flush           (in_flush),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered_value (out_filtered_value),
    .out_saturated      (out_saturated),
    .out_last_of_frame  (out_last_of_frame),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata)
  );

  // Mirror of the filter: weights, geometry, line stores, window and position.
  logic [wconv_pkg::KREG_W-1:0] kernel_regs [3];
  logic [wconv_pkg::DIM_W-1:0]  width_reg;
  logic [wconv_pkg::DIM_W-1:0]  height_reg;
  logic [wconv_pkg::PIX_W-1:0]  upper_line [wconv_pkg::MAX_WIDTH_D];
  logic [wconv_pkg::PIX_W-1:0]  lower_line [wconv_pkg::MAX_WIDTH_D];
  logic [wconv_pkg::PIX_W-1:0]  win_cells [9];
  int unsigned                  col_pos;
  int unsigned                  row_pos;

  filtered_pixel_t expected_results [$];
  int unsigned     error_count     = 0;
  int unsigned     random_items    = 0;
  bit              sender_gaps     = 1'b1;
  bit              receiver_stalls = 1'b1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("tb_top failed");
    $finish;
  end

  function automatic int unsigned clamp_dim(input logic [wconv_pkg::DIM_W-1:0] v,
                                            input int unsigned hi);
    if (v < wconv_pkg::MIN_DIM) return wconv_pkg::MIN_DIM;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic void reset_filter_model();
    int i;
    kernel_regs[0] = wconv_pkg::KERNEL_ROW_ZERO_RST;
    kernel_regs[1] = wconv_pkg::KERNEL_ROW_ONE_RST;
    kernel_regs[2] = wconv_pkg::KERNEL_ROW_TWO_RST;
    width_reg = wconv_pkg::LINE_WIDTH_RST;
    height_reg = wconv_pkg::FRAME_HEIGHT_RST;
    for (i = 0; i < wconv_pkg::MAX_WIDTH_D; i++) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    for (i = 0; i < 9; i++) win_cells[i] = '0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  // Advances the mirror by one accepted beat and queues the result it releases.
  function automatic void predict_pixel(input logic [wconv_pkg::PIX_W-1:0] pix_in,
                                        input logic flush_in);
    int unsigned w, h, ci, ri, ro, co, acc, quo, r, c;
    logic [wconv_pkg::PIX_W-1:0] pix;
    filtered_pixel_t res;
    w = clamp_dim(width_reg, wconv_pkg::MAX_WIDTH_D);
    h = clamp_dim(height_reg, wconv_pkg::MAX_HEIGHT_D);
    if (col_pos >= w || row_pos > h + 1) begin
      col_pos = 0;
      row_pos = 0;
    end
    ci = col_pos;
    ri = row_pos;
    // Flushed beats and every beat of the drain rows count as zero pixels.
    pix = (flush_in || ri >= h) ? '0 : pix_in;

    // Shift the window left and bring in the new column from the line stores.
    for (r = 0; r < 3; r++) begin
      win_cells[r*3]   = win_cells[r*3+1];
      win_cells[r*3+1] = win_cells[r*3+2];
    end
    win_cells[2] = upper_line[ci];
    win_cells[5] = lower_line[ci];
    upper_line[ci] = lower_line[ci];
    lower_line[ci] = pix;
    win_cells[8] = pix;

    // The window is centered one line plus one pixel behind the incoming beat.
    if (ri >= 2 || (ri == 1 && ci >= 1)) begin
      if (ci == 0) begin
        ro = ri - 2;
        co = w - 1;
      end else begin
        ro = ri - 1;
        co = ci - 1;
      end
      acc = 0;
      for (r = 0; r < 3; r++)
        for (c = 0; c < 3; c++)
          if (!((r == 0 && ro == 0) || (r == 2 && ro + 1 >= h) ||
                (c == 0 && co == 0) || (c == 2 && co + 1 >= w)))
            acc += 32'(win_cells[r*3+c]) *
                   32'(kernel_regs[c][wconv_pkg::WEIGHT_W*r +: wconv_pkg::WEIGHT_W]);
      quo = acc / wconv_pkg::DIVISOR;
      res.sat = quo > wconv_pkg::PIX_MAX;
      res.value = res.sat ? wconv_pkg::PIX_W'(wconv_pkg::PIX_MAX) : wconv_pkg::PIX_W'(quo);
      res.last = (ri == h + 1);
      expected_results.push_back(res);
    end

    // The last drain beat wraps back to the start of the next frame.
    if (ri == h + 1) begin
      col_pos = 0;
      row_pos = 0;
    end else begin
      col_pos = ci + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = ri + 1;
      end
    end
  endfunction

  function automatic logic [wconv_pkg::PIX_W-1:0] random_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return wconv_pkg::PIX_W'($urandom);
    endcase
  endfunction

  // Mostly small weights so that only bright windows saturate.
  function automatic logic [wconv_pkg::KREG_W-1:0] random_kernel();
    logic [wconv_pkg::KREG_W-1:0] k;
    int r;
    for (r = 0; r < 3; r++)
      k[wconv_pkg::WEIGHT_W*r +: wconv_pkg::WEIGHT_W] = ($urandom_range(0, 5) == 0) ?
          wconv_pkg::WEIGHT_W'($urandom) : wconv_pkg::WEIGHT_W'($urandom_range(0, 4));
    return k;
  endfunction

  // Geometry word with junk above the field, which the block must drop.
  function automatic logic [wconv_pkg::CFG_DATA_W-1:0] dim_word(input int unsigned v);
    logic [wconv_pkg::CFG_DATA_W-1:0] word;
    word = wconv_pkg::CFG_DATA_W'($urandom);
    word[wconv_pkg::DIM_W-1:0] = v[wconv_pkg::DIM_W-1:0];
    return word;
  endfunction

  // Holds the sender until every expected result has come and the pipeline is empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [wconv_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [wconv_pkg::CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      wconv_pkg::CFG_KERNEL_ROW_ZERO: kernel_regs[0] = data;
      wconv_pkg::CFG_KERNEL_ROW_ONE:  kernel_regs[1] = data;
      wconv_pkg::CFG_KERNEL_ROW_TWO:  kernel_regs[2] = data;
      wconv_pkg::CFG_LINE_WIDTH: begin
        width_reg = data[wconv_pkg::DIM_W-1:0];
        col_pos = 0;
        row_pos = 0;
      end
      wconv_pkg::CFG_FRAME_HEIGHT: begin
        height_reg = data[wconv_pkg::DIM_W-1:0];
        col_pos = 0;
        row_pos = 0;
      end
      default: ;
    endcase
  endtask

  // Sends one beat, with an optional gap before it, and predicts once it is taken.
  task automatic send_beat(input logic [wconv_pkg::PIX_W-1:0] pix, input logic flush_bit);
    int unsigned gap;
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_value <= pix;
    in_flush <= flush_bit;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pixel(pix, flush_bit);
  endtask

  // Receiver back-pressure in short random bursts.
  initial begin
    forever begin
      @(posedge clk);
      if (receiver_stalls && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Every result beat is compared with the oldest prediction.
  always @(posedge clk) begin
    filtered_pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result value=%0d sat=%0b last=%0b", $time,
                 out_filtered_value, out_saturated, out_last_of_frame);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_filtered_value !== want.value) begin
          $display("%0t: filtered_value expected %0d, got %0d", $time, want.value,
                   out_filtered_value);
          error_count++;
        end
        if (out_saturated !== want.sat) begin
          $display("%0t: saturated expected %0b, got %0b", $time, want.sat, out_saturated);
          error_count++;
        end
        if (out_last_of_frame !== want.last) begin
          $display("%0t: last_of_frame expected %0b, got %0b", $time, want.last,
                   out_last_of_frame);
          error_count++;
        end
      end
    end
  end

  // One frame at the reset geometry and weights: full-scale, dark and mixed rows,
  // a flushed beat inside the frame and live pixels during the drain.
  task automatic test_default_frame();
    int unsigned k;
    logic [wconv_pkg::PIX_W-1:0] pix;
    for (k = 0; k < 20; k++) begin
      case (k / 5)
        0: pix = '1;
        1: pix = '0;
        default: pix = wconv_pkg::PIX_W'(k * 53);
      endcase
      send_beat(pix, k == 12);
    end
    for (k = 0; k < 6; k++) send_beat(8'hA5 ^ wconv_pkg::PIX_W'(k), k[0]);
  endtask

  // Full-scale weights on a bright minimum frame clip every result.
  task automatic test_saturation();
    int unsigned k;
    write_reg(wconv_pkg::CFG_KERNEL_ROW_ZERO, '1);
    write_reg(wconv_pkg::CFG_KERNEL_ROW_ONE, '1);
    write_reg(wconv_pkg::CFG_KERNEL_ROW_TWO, '1);
    write_reg(wconv_pkg::CFG_LINE_WIDTH, dim_word(wconv_pkg::MIN_DIM));
    write_reg(wconv_pkg::CFG_FRAME_HEIGHT, dim_word(wconv_pkg::MIN_DIM));
    for (k = 0; k < 13; k++) send_beat('1, k >= 9);
    write_reg(wconv_pkg::CFG_KERNEL_ROW_ZERO, wconv_pkg::KERNEL_ROW_ZERO_RST);
    write_reg(wconv_pkg::CFG_KERNEL_ROW_ONE, wconv_pkg::KERNEL_ROW_ONE_RST);
    write_reg(wconv_pkg::CFG_KERNEL_ROW_TWO, wconv_pkg::KERNEL_ROW_TWO_RST);
  endtask

  // Writes to unused indexes must leave weights and geometry alone.
  task automatic test_unused_registers();
    int a;
    int unsigned k;
    logic [wconv_pkg::CFG_DATA_W-1:0] spare_data;
    for (a = CFG_SPARE_FIRST; a <= CFG_SPARE_LAST; a++) begin
      spare_data = (a == CFG_SPARE_FIRST) ? '1 : wconv_pkg::CFG_DATA_W'($urandom);
      write_reg(a[wconv_pkg::CFG_ADDR_W-1:0], spare_data);
    end
    for (k = 0; k < 13; k++) send_beat(random_pixel(), k >= 9);
  endtask

  // Geometry below the minimum, then a height field above the maximum.
  task automatic test_geometry_limits();
    int unsigned k;
    write_reg(wconv_pkg::CFG_LINE_WIDTH, dim_word(0));
    write_reg(wconv_pkg::CFG_FRAME_HEIGHT, dim_word(1));
    for (k = 0; k < 13; k++) send_beat(random_pixel(), k >= 9);

    // Narrow line raised to three, height field at its top value cut to the deepest
    // frame; the first rows run with no bottom edge and the frame is abandoned.
    write_reg(wconv_pkg::CFG_LINE_WIDTH, dim_word(wconv_pkg::MIN_DIM - 1));
    write_reg(wconv_pkg::CFG_FRAME_HEIGHT, dim_word(DIM_FIELD_MAX));
    for (k = 0; k < 30; k++) send_beat(random_pixel(), 1'b0);
  endtask

  // Random weights and small frames; most frames complete, a few cut short.
  task automatic test_random_frames();
    int unsigned w, h, k, nframes, f, cut, frame_len;
    bit broken;
    while (random_items < RANDOM_ITEMS) begin
      // A new setting; the geometry write restarts the frame.
      if ($urandom_range(0, 1)) write_reg(wconv_pkg::CFG_KERNEL_ROW_ZERO, random_kernel());
      if ($urandom_range(0, 1)) write_reg(wconv_pkg::CFG_KERNEL_ROW_ONE, random_kernel());
      if ($urandom_range(0, 1)) write_reg(wconv_pkg::CFG_KERNEL_ROW_TWO, random_kernel());
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
      write_reg(wconv_pkg::CFG_LINE_WIDTH, dim_word(w));
      write_reg(wconv_pkg::CFG_FRAME_HEIGHT, dim_word(h));
      w = clamp_dim(wconv_pkg::DIM_W'(w), wconv_pkg::MAX_WIDTH_D);
      h = clamp_dim(wconv_pkg::DIM_W'(h), wconv_pkg::MAX_HEIGHT_D);
      frame_len = w * h + w + 1;
      nframes = $urandom_range(1, 3);
      broken = 1'b0;
      for (f = 0; f < nframes && !broken; f++) begin
        cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, frame_len - 1) : frame_len;
        for (k = 0; k < cut; k++) begin
          if (k < w * h) send_beat(random_pixel(), $urandom_range(0, 19) == 0);
          else send_beat(random_pixel(), $urandom_range(0, 5) != 0);
          random_items++;
        end
        broken = (cut < frame_len);
        // Now and then the sender holds until every result is back.
        if ($urandom_range(0, 3) == 0) wait_idle();
      end
    end
  endtask

  // Back-to-back frames with no gaps and no back-pressure.
  task automatic test_steady_stream();
    int unsigned k;
    sender_gaps = 1'b0;
    receiver_stalls = 1'b0;
    write_reg(wconv_pkg::CFG_KERNEL_ROW_ONE, random_kernel());
    write_reg(wconv_pkg::CFG_LINE_WIDTH, dim_word(6));
    write_reg(wconv_pkg::CFG_FRAME_HEIGHT, dim_word(wconv_pkg::MIN_DIM));
    for (k = 0; k < 50; k++) send_beat(random_pixel(), (k % 25) >= 18);
  endtask

  initial begin
    int unsigned drain_cycles;
    reset_filter_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_frame();
    test_saturation();
    test_unused_registers();
    test_geometry_limits();
    test_random_frames();
    test_steady_stream();

    // Let the remaining results drain, then allow for the pipeline depth.
    in_valid <= 1'b0;
    drain_cycles = 0;
    while (expected_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      error_count++;
    end
    if (error_count == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule

FILE: files.f
design/wconv_pkg.sv
design/weighted_3x3_convolution.sv
tb/tb_top.sv
